/* src/pbld_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pbld_pkg;

  localparam int COUNT_WIDTH_DEF = 16;
  localparam int TICK_W          = 16;
  localparam int LEVEL_W         = 8;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 16;
  localparam int IN_TDATA_W      = 8;
  localparam int OUT_TDATA_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_ON_LEVEL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LEVEL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL     = 3'd5;

  localparam logic [TICK_W-1:0]  LONG_PRESS_RST    = 16'd250;
  localparam logic [TICK_W-1:0]  RAMP_INTERVAL_RST = 16'd50;
  localparam logic [LEVEL_W-1:0] STEP_SIZE_RST     = 8'd13;
  localparam logic [LEVEL_W-1:0] TURN_ON_LEVEL_RST = 8'd100;
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST     = 8'd2;
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST     = 8'd255;

  typedef struct packed {
    logic [TICK_W-1:0]  long_press_ticks;
    logic [TICK_W-1:0]  ramp_interval_ticks;
    logic [LEVEL_W-1:0] step_size;
    logic [LEVEL_W-1:0] turn_on_level;
    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] max_level;
  } cfg_t;

  typedef struct packed {
    logic               brightening;
    logic               light_on;
    logic [LEVEL_W-1:0] duty;
  } result_t;

endpackage
`default_nettype wire

/* src/pbld_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none
module pbld_cfg (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [pbld_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pbld_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output pbld_pkg::cfg_t                        cfg
);

  pbld_pkg::cfg_t cfg_r;
  pbld_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pbld_pkg::REG_LONG_PRESS:    cfg_nxt.long_press_ticks    = cfg_wdata;
        pbld_pkg::REG_RAMP_INTERVAL: cfg_nxt.ramp_interval_ticks = cfg_wdata;
        pbld_pkg::REG_STEP_SIZE:     cfg_nxt.step_size     = cfg_wdata[pbld_pkg::LEVEL_W-1:0];
        pbld_pkg::REG_TURN_ON_LEVEL: cfg_nxt.turn_on_level = cfg_wdata[pbld_pkg::LEVEL_W-1:0];
        pbld_pkg::REG_MIN_LEVEL:     cfg_nxt.min_level     = cfg_wdata[pbld_pkg::LEVEL_W-1:0];
        pbld_pkg::REG_MAX_LEVEL:     cfg_nxt.max_level     = cfg_wdata[pbld_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_ticks    <= pbld_pkg::LONG_PRESS_RST;
      cfg_r.ramp_interval_ticks <= pbld_pkg::RAMP_INTERVAL_RST;
      cfg_r.step_size           <= pbld_pkg::STEP_SIZE_RST;
      cfg_r.turn_on_level       <= pbld_pkg::TURN_ON_LEVEL_RST;
      cfg_r.min_level           <= pbld_pkg::MIN_LEVEL_RST;
      cfg_r.max_level           <= pbld_pkg::MAX_LEVEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

/* src/pbld_core.sv */
`timescale 1ns / 1ps
`default_nettype none
module pbld_core #(
  parameter int COUNT_WIDTH = pbld_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       accept,
  input  wire logic       button_level,
  input  pbld_pkg::cfg_t  cfg,
  output pbld_pkg::result_t result
);

  localparam int CMP_W = (COUNT_WIDTH > pbld_pkg::TICK_W) ? COUNT_WIDTH : pbld_pkg::TICK_W;
  localparam int LW    = pbld_pkg::LEVEL_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic [LW-1:0]          level_r, level_nxt;
  logic                   on_r, on_nxt;
  logic                   dir_up_r, dir_up_nxt;
  logic                   prev_r, prev_nxt;
  logic [COUNT_WIDTH-1:0] hold_r, hold_nxt;
  logic [COUNT_WIDTH-1:0] intv_r, intv_nxt;

  logic [COUNT_WIDTH-1:0] hold_inc;
  logic [COUNT_WIDTH-1:0] intv_inc;
  logic [LW:0]            up_sum;
  logic [LW:0]            floor_sum;
  logic [LW-1:0]          lvl;

  always_comb begin
    hold_inc  = (prev_r && hold_r != CNT_MAX) ? hold_r + 1'b1 : hold_r;
    intv_inc  = (intv_r != CNT_MAX) ? intv_r + 1'b1 : intv_r;
    on_nxt    = on_r;
    dir_up_nxt = dir_up_r;
    lvl       = level_r;
    hold_nxt  = hold_inc;
    if (button_level && !prev_r) begin
      hold_nxt = '0;
    end else if (!button_level && prev_r) begin
      if (CMP_W'(hold_inc) < CMP_W'(cfg.long_press_ticks)) begin
        on_nxt = !on_r;
        if (!on_r) lvl = cfg.turn_on_level;
      end else begin
        dir_up_nxt = !dir_up_r;
      end
    end
    prev_nxt = button_level;
    if (!on_nxt) lvl = '0;

    up_sum    = {1'b0, lvl} + {1'b0, cfg.step_size};
    floor_sum = {1'b0, cfg.min_level} + {1'b0, cfg.step_size};
    level_nxt = lvl;
    intv_nxt  = intv_inc;
    if (CMP_W'(intv_inc) > CMP_W'(cfg.ramp_interval_ticks)) begin
      intv_nxt = '0;
      if (on_nxt && button_level &&
          CMP_W'(hold_nxt) > CMP_W'(cfg.long_press_ticks)) begin
        if (dir_up_nxt) begin
          if (lvl < cfg.max_level)
            level_nxt = (up_sum > {1'b0, cfg.max_level}) ? cfg.max_level : up_sum[LW-1:0];
        end else begin
          if (lvl > cfg.min_level)
            level_nxt = ({1'b0, lvl} < floor_sum) ? cfg.min_level : lvl - cfg.step_size;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r  <= '0;
      on_r     <= 1'b0;
      dir_up_r <= 1'b1;
      prev_r   <= 1'b0;
      hold_r   <= '0;
      intv_r   <= '0;
    end else if (accept) begin
      level_r  <= level_nxt;
      on_r     <= on_nxt;
      dir_up_r <= dir_up_nxt;
      prev_r   <= prev_nxt;
      hold_r   <= hold_nxt;
      intv_r   <= intv_nxt;
    end
  end

  assign result.duty        = level_nxt;
  assign result.light_on    = on_nxt;
  assign result.brightening = dir_up_nxt;

endmodule
`default_nettype wire

/* src/pbld_outreg.sv */
`timescale 1ns / 1ps
`default_nettype none
module pbld_outreg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  pbld_pkg::result_t  in_result,
  output logic               out_valid,
  input  wire logic          out_ready,
  output pbld_pkg::result_t  out_result
);

  logic              valid_r, valid_nxt;
  pbld_pkg::result_t data_r;

  assign in_ready  = !valid_r || out_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) data_r <= in_result;
  end

  assign out_valid  = valid_r;
  assign out_result = data_r;

endmodule
`default_nettype wire

/* src/push_button_led_dimmer_unit.sv */
// channel  | dir | ports                         | contents
// ---------+-----+-------------------------------+-----------------------------------
// in       | in  | in_tvalid/in_tready/in_tdata  | one tick: button level
// out      | out | out_tvalid/out_tready/out_tdata | duty, light_on, brightening
// cfg      | in  | cfg_we/cfg_index/cfg_wdata    | register writes, no read-back
//
// One item per clock while the output is not stalled: the state update for a tick is done in the accepting cycle,
// its result sits in the output register from the cycle after.
// Synchronous active-low reset: light off, level 0, direction up, registers to defaults.
// A stalled output holds; input is taken while the output register is empty or draining.
`timescale 1ns / 1ps
`default_nettype none
module push_button_led_dimmer_unit #(
  parameter int COUNT_WIDTH = pbld_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [pbld_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] button_level
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [pbld_pkg::OUT_TDATA_W-1:0]      out_tdata,  // [7:0] duty, [8] light_on, [9] brightening
  input  wire logic                             cfg_we,
  input  wire logic [pbld_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pbld_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  pbld_pkg::cfg_t    cfg;
  pbld_pkg::result_t core_result;
  pbld_pkg::result_t out_result;
  logic              accept;

  assign accept = in_tvalid && in_tready;

  pbld_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pbld_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .button_level (in_tdata[0]),
    .cfg          (cfg),
    .result       (core_result)
  );

  pbld_outreg u_outreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_result  (core_result),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_result (out_result)
  );

  assign out_tdata = {{(pbld_pkg::OUT_TDATA_W - $bits(pbld_pkg::result_t)){1'b0}}, out_result};

`ifndef NO_ASSERTIONS
  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[8] |-> out_tdata[7:0] == '0)
    else $error("light off but duty nonzero");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output register");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

/* tb/sv/push_button_led_dimmer_unit_tb.sv */
`timescale 1ns / 1ps
module push_button_led_dimmer_unit_tb;
  import pbld_pkg::*;

  localparam int CNT_MAX     = 65535;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_PRINTS  = 40;
  localparam int N_DIR       = 26;
  localparam int N_RAND      = 250;
  localparam int HOLD_LEN    = 250;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  // {brightening, light_on, duty}
  localparam result_t OFF_UP  = {1'b1, 1'b0, 8'd0};
  localparam result_t ON_100  = {1'b1, 1'b1, 8'd100};

  typedef struct {
    logic    btn;
    bit      fixed;
    result_t exp;
  } tick_t;

  typedef struct {
    int      grp;
    logic    btn;
    bit      fixed;
    result_t exp;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [0] button_level
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // [7:0] duty, [8] light_on, [9] brightening
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  always #1 clk = ~clk;

  push_button_led_dimmer_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // dimmer state mirror
  cfg_t        cfg_q;
  logic [7:0]  lvl_q;
  bit          on_q, up_q, prev_q;
  int unsigned hold_q, intv_q;

  tick_t   tick_q[$];
  result_t pwm_exp_q[$];

  bit run_en = 1'b0;
  bit calm = 1'b0;
  bit in_acc = 1'b0;
  int n_err = 0;
  int n_ticks = 0;
  int n_steps = 0;
  int n_cfg = 0;
  int cycles = 0;

  function automatic cfg_t make_cfg(int lp, int ri, int st, int to, int mn, int mx);
    cfg_t c;
    c.long_press_ticks    = lp[15:0];
    c.ramp_interval_ticks = ri[15:0];
    c.step_size           = st[7:0];
    c.turn_on_level       = to[7:0];
    c.min_level           = mn[7:0];
    c.max_level           = mx[7:0];
    return c;
  endfunction

  task dimmer_tick(input logic btn, output result_t r);
    int lv, mn, mx, st;
    if (prev_q) hold_q = (hold_q >= CNT_MAX) ? CNT_MAX : hold_q + 1;
    if (btn && !prev_q) begin
      hold_q = 0;
    end else if (!btn && prev_q) begin
      if (hold_q < cfg_q.long_press_ticks) begin
        on_q = !on_q;
        if (on_q) lvl_q = cfg_q.turn_on_level;
      end else begin
        up_q = !up_q;
      end
    end
    prev_q = btn;
    if (!on_q) lvl_q = '0;
    intv_q = (intv_q >= CNT_MAX) ? CNT_MAX : intv_q + 1;
    if (intv_q > cfg_q.ramp_interval_ticks) begin
      intv_q = 0;
      if (on_q && btn && hold_q > cfg_q.long_press_ticks) begin
        n_steps++;
        lv = lvl_q;
        mn = cfg_q.min_level;
        mx = cfg_q.max_level;
        st = cfg_q.step_size;
        if (up_q) begin
          if (lv < mx) lv = (lv + st > mx) ? mx : lv + st;
        end else if (lv > mn) begin
          lv = (lv < mn + st) ? mn : lv - st;
        end
        lvl_q = lv[7:0];
      end
    end
    r.duty        = lvl_q;
    r.light_on    = on_q;
    r.brightening = up_q;
  endtask

  task report(input string field, input int want, input int got);
    n_err++;
    if (n_err <= MAX_PRINTS)
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
  endtask

  task push_tick(input logic btn);
    tick_t t;
    t.btn   = btn;
    t.fixed = 1'b0;
    t.exp   = '0;
    tick_q.push_back(t);
  endtask

  task reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
  endtask

  // upper bits of the byte registers carry junk, the block must mask them
  task apply_cfg(input cfg_t c);
    reg_write(REG_LONG_PRESS, c.long_press_ticks);
    reg_write(REG_RAMP_INTERVAL, c.ramp_interval_ticks);
    reg_write(REG_STEP_SIZE, {8'($urandom), c.step_size});
    reg_write(REG_TURN_ON_LEVEL, {8'($urandom), c.turn_on_level});
    reg_write(REG_MIN_LEVEL, {8'($urandom), c.min_level});
    reg_write(REG_MAX_LEVEL, {8'($urandom), c.max_level});
    reg_write(REG_UNUSED_6, 16'($urandom));
    reg_write(REG_UNUSED_7, 16'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_q = c;
    n_cfg++;
  endtask

  task drain;
    while (tick_q.size() != 0 || pwm_exp_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // mostly well-formed presses around the long-press threshold
  task gen_presses(input int n, input int lp, input int ri);
    int cnt, k, len, j;
    cnt = 0;
    while (cnt < n) begin
      k = $urandom_range(0, 9);
      len = $urandom_range(0, 3);
      for (j = 0; j < len; j++) push_tick(1'b0);
      cnt += len;
      if (k >= 8) begin
        len = $urandom_range(1, 6);
        for (j = 0; j < len; j++) push_tick(1'($urandom));
      end else begin
        if (k <= 2)
          len = $urandom_range(1, (lp > 1) ? lp - 1 : 1);
        else if (k == 3)
          len = $urandom_range((lp > 1) ? lp - 1 : 1, lp + 1);
        else
          len = lp + 1 + $urandom_range(0, 6 * (ri + 1));
        for (j = 0; j < len; j++) push_tick(1'b1);
      end
      push_tick(1'b0);
      cnt += len + 1;
    end
  endtask

  always @(negedge clk) begin : drive_blk
    bit go;
    if (!(in_tvalid && !in_acc)) begin
      go = run_en && tick_q.size() != 0 && (calm || $urandom_range(0, 99) >= 25);
      in_tvalid <= go;
      in_tdata  <= go ? {{(IN_TDATA_W-1){1'b0}}, tick_q[0].btn} : '0;
    end
    out_tready <= run_en && (calm || $urandom_range(0, 99) >= 25);
  end

  always @(posedge clk) begin : mon_blk
    tick_t   t;
    result_t r;
    result_t got;
    result_t want;
    in_acc = rst_n && in_tvalid && in_tready;
    if (in_acc && tick_q.size() != 0) begin
      t = tick_q.pop_front();
      dimmer_tick(t.btn, r);
      pwm_exp_q.push_back(t.fixed ? t.exp : r);
      n_ticks++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(result_t)-1:0];
      if (pwm_exp_q.size() == 0) begin
        report("unexpected item, duty", -1, got.duty);
      end else begin
        want = pwm_exp_q.pop_front();
        if (got.duty !== want.duty) report("duty", want.duty, got.duty);
        if (got.light_on !== want.light_on) report("light_on", want.light_on, got.light_on);
        if (got.brightening !== want.brightening)
          report("brightening", want.brightening, got.brightening);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected", cycles, pwm_exp_q.size());
      $display("** push_button_led_dimmer_unit: FAILED **");
      $finish;
    end
  end

  initial begin : main_blk
    dir_row_t dir_rows[N_DIR];
    cfg_t     dir_cfg[3];
    cfg_t     c;
    tick_t    t;
    int       i, p, cur_grp, lp, ri;

    cfg_q = make_cfg(LONG_PRESS_RST, RAMP_INTERVAL_RST, STEP_SIZE_RST,
                     TURN_ON_LEVEL_RST, MIN_LEVEL_RST, MAX_LEVEL_RST);
    lvl_q  = '0;
    on_q   = 1'b0;
    up_q   = 1'b1;
    prev_q = 1'b0;
    hold_q = 0;
    intv_q = 0;

    dir_cfg[0] = cfg_q;
    dir_cfg[1] = make_cfg(0, 0, 13, 100, 2, 255);       // zero threshold: every release is long
    dir_cfg[2] = make_cfg(2, 0, 100, 250, 30, 200);     // turn-on above max, clamps both ways
    dir_rows = '{
      '{0, 1'b0, 1'b1, OFF_UP}, '{0, 1'b1, 1'b1, OFF_UP}, '{0, 1'b0, 1'b1, ON_100},
      '{0, 1'b0, 1'b1, ON_100}, '{0, 1'b1, 1'b1, ON_100}, '{0, 1'b0, 1'b1, OFF_UP},
      '{1, 1'b1, 1'b0, '0}, '{1, 1'b1, 1'b0, '0}, '{1, 1'b0, 1'b0, '0},
      '{1, 1'b1, 1'b0, '0}, '{1, 1'b0, 1'b0, '0},
      '{2, 1'b1, 1'b0, '0}, '{2, 1'b0, 1'b0, '0}, '{2, 1'b1, 1'b0, '0},
      '{2, 1'b1, 1'b0, '0}, '{2, 1'b1, 1'b0, '0}, '{2, 1'b1, 1'b0, '0},
      '{2, 1'b0, 1'b0, '0}, '{2, 1'b1, 1'b0, '0}, '{2, 1'b1, 1'b0, '0},
      '{2, 1'b1, 1'b0, '0}, '{2, 1'b1, 1'b0, '0}, '{2, 1'b1, 1'b0, '0},
      '{2, 1'b1, 1'b0, '0}, '{2, 1'b1, 1'b0, '0}, '{2, 1'b0, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    run_en = 1'b1;

    cur_grp = 0;
    for (i = 0; i < N_DIR; i++) begin
      if (dir_rows[i].grp != cur_grp) begin
        cur_grp = dir_rows[i].grp;
        drain();
        apply_cfg(dir_cfg[cur_grp]);
      end
      t.btn   = dir_rows[i].btn;
      t.fixed = dir_rows[i].fixed;
      t.exp   = dir_rows[i].exp;
      tick_q.push_back(t);
    end

    for (p = 0; p < 7; p++) begin
      case (p)
        1: c = make_cfg(1, 0, 255, 255, 0, 255);
        2: c = make_cfg(65535, 65535, $urandom_range(1, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255));
        3: c = make_cfg(2, 0, 1, 0, 255, 0);           // min above max
        6: c = make_cfg($urandom_range(1, 40), $urandom_range(0, 20), $urandom_range(1, 255),
                        $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        default: c = make_cfg($urandom_range(1, 20), $urandom_range(0, 8),
                              $urandom_range(1, 255), $urandom_range(0, 255),
                              $urandom_range(0, 120), $urandom_range(130, 255));
      endcase
      drain();
      apply_cfg(c);
      if (p == 2) begin
        // a long and a short hold, both short presses under the maximal thresholds, no idling here
        calm = 1'b1;
        for (i = 0; i < HOLD_LEN; i++) push_tick(1'b1);
        for (i = 0; i < 6; i++) push_tick(1'b0);
        for (i = 0; i < 10; i++) push_tick(1'b1);
        push_tick(1'b0);
        drain();
        calm = 1'b0;
      end else begin
        lp = c.long_press_ticks;
        ri = c.ramp_interval_ticks;
        gen_presses(N_RAND, lp, ri);
      end
    end
    drain();

    $display("%0d ticks checked under %0d register settings, %0d ramp steps taken,",
             n_ticks, n_cfg, n_steps);
    $display("including a stretch without idling against maximal press and ramp thresholds");
    if (n_err == 0)
      $display("** push_button_led_dimmer_unit: PASSED **");
    else
      $display("** push_button_led_dimmer_unit: FAILED **");
    $finish;
  end

endmodule

/* files.f */
src/pbld_pkg.sv
src/pbld_cfg.sv
src/pbld_core.sv
src/pbld_outreg.sv
src/push_button_led_dimmer_unit.sv
tb/sv/push_button_led_dimmer_unit_tb.sv
